// ----- design/ftnp_pkg.sv -----
package ftnp_pkg;

    localparam int NETS_DEF      = 4;
    localparam int PORTS_DEF     = 64;
    localparam int LOAD_BITS_DEF = 48;

    localparam int RATE_BITS     = 19;
    localparam int RATE_REGS     = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int EPOCH_BITS    = 8;
    localparam int NET_BITS_MAX  = 3;

    localparam logic [RATE_BITS-1:0] RATE0_RESET = 19'd100000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE3 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE  = 3'd4;

    typedef struct packed {
        logic        first_of_group;
        logic        has_demand;
        logic [5:0]  src_port;
        logic [5:0]  dst_port;
        logic [39:0] bits_left;
    } t_req;

    typedef struct packed {
        logic [1:0] chosen_net;
        logic       raises_bottleneck;
        logic       load_saturated;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_LOAD,
        S_EVAL,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD,
        S_CMP,
        S_PASS_END,
        S_WB_READ,
        S_WB_LOAD,
        S_WB_WRITE
    } t_state;

    typedef struct packed {
        logic                    latch;
        logic                    sweep;
        logic                    rd;
        logic                    use_best;
        logic                    ld;
        logic                    ev;
        logic                    pass;
        logic                    mlo;
        logic                    mhi;
        logic                    add;
        logic                    cmp;
        logic                    pass_start;
        logic                    wld;
        logic                    write;
        logic                    emit_dummy;
        logic                    emit_none;
        logic [NET_BITS_MAX-1:0] net;
    } t_cmd;

    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
        logic has_demand;
        logic rate_zero;
        logic best_vld;
        logic crit;
        logic mode;
    } t_stat;

endpackage

// ----- design/flow_to_network_placement.sv -----
// A flow without demand strobes o_done with the fastest enabled network. A flow
// with demand runs a pass over the networks, skipping disabled ones, and may run a ratio
// pass; with no enabled network it strobes o_done with a zero result. A group start with
// the epoch tag at its maximum first clears the load table.
// Throughput: one flow at a time; a new start is taken in the cycle o_done is high, and the
// receiver cannot stall. Reset (synchronous, active low) starts a clear of the whole table.
module flow_to_network_placement #(
    parameter int NETS      = ftnp_pkg::NETS_DEF,
    parameter int PORTS     = ftnp_pkg::PORTS_DEF,
    parameter int LOAD_BITS = ftnp_pkg::LOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ftnp_pkg::t_req                    i_req,
    output logic                              o_done,
    output ftnp_pkg::t_result                 o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ftnp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ftnp_pkg::RATE_BITS-1:0]    i_cfg_data
);
    import ftnp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    ftnp_ctrl #(
        .NETS (NETS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    ftnp_datapath #(
        .NETS      (NETS),
        .PORTS     (PORTS),
        .LOAD_BITS (LOAD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

// ----- design/ftnp_ctrl.sv -----
module ftnp_ctrl #(
    parameter int NETS = ftnp_pkg::NETS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ftnp_pkg::t_stat i_stat,
    output ftnp_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import ftnp_pkg::*;

    localparam int NW = (NETS > 1) ? $clog2(NETS) : 1;

    t_state          r_state, n_state;
    logic [NW-1:0]   r_net, n_net;
    logic            r_pass, n_pass;
    logic            r_pending, n_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_net     <= '0;
            r_pass    <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_net     <= n_net;
            r_pass    <= n_pass;
            r_pending <= n_pending;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_net     = r_net;
        n_pass    = r_pass;
        n_pending = r_pending;
        o_cmd     = '0;
        o_cmd.net  = NET_BITS_MAX'(r_net);
        o_cmd.pass = r_pass;
        o_busy    = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state   = r_pending ? S_DISPATCH : S_IDLE;
                    n_pending = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    if (i_stat.need_sweep) begin
                        n_state   = S_CLEAR;
                        n_pending = 1'b1;
                    end else begin
                        n_state = S_DISPATCH;
                    end
                end
            end
            S_DISPATCH: begin
                if (!i_stat.has_demand) begin
                    o_cmd.emit_dummy = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_net   = '0;
                    n_pass  = 1'b0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.rate_zero) begin
                    if (r_net == NW'(NETS - 1)) begin
                        n_state = S_PASS_END;
                    end else begin
                        n_net = r_net + 1'b1;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.ld = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.ev = 1'b1;
                // The first candidate of a pass is taken without a compare.
                n_state  = i_stat.best_vld ? S_MUL_LO : S_CMP;
            end
            S_MUL_LO: begin
                o_cmd.mlo = 1'b1;
                n_state   = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mhi = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (r_net == NW'(NETS - 1)) begin
                    n_state = S_PASS_END;
                end else begin
                    n_net   = r_net + 1'b1;
                    n_state = S_READ;
                end
            end
            S_PASS_END: begin
                if (!i_stat.best_vld) begin
                    o_cmd.emit_none = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_pass && !i_stat.crit && i_stat.mode) begin
                    o_cmd.pass_start = 1'b1;
                    n_pass  = 1'b1;
                    n_net   = '0;
                    n_state = S_READ;
                end else begin
                    n_state = S_WB_READ;
                end
            end
            S_WB_READ: begin
                o_cmd.rd       = 1'b1;
                o_cmd.use_best = 1'b1;
                n_state        = S_WB_LOAD;
            end
            S_WB_LOAD: begin
                o_cmd.wld      = 1'b1;
                o_cmd.use_best = 1'b1;
                n_state        = S_WB_WRITE;
            end
            S_WB_WRITE: begin
                o_cmd.write    = 1'b1;
                o_cmd.use_best = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ftnp_datapath.sv -----
module ftnp_datapath #(
    parameter int NETS      = ftnp_pkg::NETS_DEF,
    parameter int PORTS     = ftnp_pkg::PORTS_DEF,
    parameter int LOAD_BITS = ftnp_pkg::LOAD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [ftnp_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ftnp_pkg::RATE_BITS-1:0]      i_cfg_data,
    input  ftnp_pkg::t_req                      i_req,
    input  ftnp_pkg::t_cmd                      i_cmd,
    output ftnp_pkg::t_stat                     o_stat,
    output logic                                o_done,
    output ftnp_pkg::t_result                   o_result
);
    import ftnp_pkg::*;

    localparam int LB    = LOAD_BITS;
    localparam int NW    = (NETS > 1) ? $clog2(NETS) : 1;
    localparam int PW    = $clog2(PORTS);
    localparam int AW    = NW + PW;
    localparam int DEPTH = 1 << AW;
    localparam int HB    = (LB + 1) / 2;
    localparam int HW    = LB - HB;
    localparam int MLW   = HB + RATE_BITS;
    localparam int MHW   = HW + RATE_BITS;
    localparam int PDW   = LB + RATE_BITS;
    localparam int WW    = EPOCH_BITS + LB;

    function automatic logic [LB-1:0] sat_add(input logic [LB-1:0] a, input logic [LB-1:0] b);
        logic [LB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LB] ? {LB{1'b1}} : s[LB-1:0];
    endfunction

    function automatic logic [LB-1:0] umax(input logic [LB-1:0] a, input logic [LB-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Configuration registers.
    logic [RATE_BITS-1:0] r_rate [RATE_REGS];
    logic                 r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate[0] <= RATE0_RESET;
            for (int k = 1; k < RATE_REGS; k++) begin
                r_rate[k] <= '0;
            end
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RATE0: r_rate[0] <= i_cfg_data;
                REG_RATE1: r_rate[1] <= i_cfg_data;
                REG_RATE2: r_rate[2] <= i_cfg_data;
                REG_RATE3: r_rate[3] <= i_cfg_data;
                REG_MODE:  r_mode    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic [RATE_BITS-1:0] w_net_rate [NETS];
    for (genvar n = 0; n < NETS; n++) begin : g_rate
        if (n < RATE_REGS) begin : g_reg
            assign w_net_rate[n] = r_rate[n];
        end else begin : g_none
            assign w_net_rate[n] = '0;
        end
    end

    // Port index reduced modulo the port count.
    logic [PW-1:0] w_port_mod [64];
    for (genvar v = 0; v < 64; v++) begin : g_mod
        assign w_port_mod[v] = PW'(v % PORTS);
    end

    t_req            r_req;
    logic [PW-1:0]   r_sp, r_dp;
    logic [LB-1:0]   w_bits;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
            r_sp  <= w_port_mod[i_req.src_port];
            r_dp  <= w_port_mod[i_req.dst_port];
        end
    end
    assign w_bits = LB'(r_req.bits_left);

    // Epoch tags mark which load entries belong to the current group.
    logic [EPOCH_BITS-1:0] r_epoch;
    logic [AW-1:0]         r_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_BITS'(1);
            r_sweep <= '0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + 1'b1;
                if (&r_sweep) begin
                    r_epoch <= EPOCH_BITS'(1);
                end
            end else if (i_cmd.latch && i_req.first_of_group && !(&r_epoch)) begin
                r_epoch <= r_epoch + 1'b1;
            end
        end
    end

    logic [NW-1:0] r_best;
    logic [NW-1:0] w_sel;
    assign w_sel = i_cmd.use_best ? r_best : NW'(i_cmd.net);

    // Load memories, one word per network and port.
    logic [WW-1:0] r_mem_src [DEPTH];
    logic [WW-1:0] r_mem_dst [DEPTH];
    logic [WW-1:0] r_rd_src, r_rd_dst;
    logic [LB-1:0] r_ns, r_nd;
    logic [AW-1:0] w_wa_s, w_wa_d;
    logic [WW-1:0] w_wd_s, w_wd_d;
    logic          w_we;

    assign w_we   = i_cmd.sweep | i_cmd.write;
    assign w_wa_s = i_cmd.sweep ? r_sweep : {r_best, r_sp};
    assign w_wa_d = i_cmd.sweep ? r_sweep : {r_best, r_dp};
    assign w_wd_s = i_cmd.sweep ? '0 : {r_epoch, r_ns};
    assign w_wd_d = i_cmd.sweep ? '0 : {r_epoch, r_nd};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_src[w_wa_s] <= w_wd_s;
            r_mem_dst[w_wa_d] <= w_wd_d;
        end
        if (i_cmd.rd) begin
            r_rd_src <= r_mem_src[{w_sel, r_sp}];
            r_rd_dst <= r_mem_dst[{w_sel, r_dp}];
        end
    end

    logic [LB-1:0] w_ld_s, w_ld_d;
    assign w_ld_s = (r_rd_src[WW-1:LB] == r_epoch) ? r_rd_src[LB-1:0] : '0;
    assign w_ld_d = (r_rd_dst[WW-1:LB] == r_epoch) ? r_rd_dst[LB-1:0] : '0;

    // Per-network maxima.
    logic [LB-1:0] r_maxs [NETS];
    logic [LB-1:0] r_maxd [NETS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NETS; n++) begin
                r_maxs[n] <= '0;
                r_maxd[n] <= '0;
            end
        end else if (i_cmd.latch && i_req.first_of_group) begin
            for (int n = 0; n < NETS; n++) begin
                r_maxs[n] <= '0;
                r_maxd[n] <= '0;
            end
        end else if (i_cmd.write) begin
            r_maxs[r_best] <= umax(r_maxs[r_best], r_ns);
            r_maxd[r_best] <= umax(r_maxd[r_best], r_nd);
        end
    end

    // Candidate evaluation and exact quotient compare.
    logic [LB-1:0]        r_as, r_ad, r_base, r_q, r_bq;
    logic [RATE_BITS-1:0] r_r, r_br;
    logic [MLW-1:0]       r_m1lo, r_m2lo;
    logic [MHW-1:0]       r_m1hi, r_m2hi;
    logic [PDW-1:0]       r_p1, r_p2;
    logic                 r_best_vld, r_crit;
    logic [LB-1:0]        w_m;
    logic                 w_better;

    assign w_m      = umax(r_as, r_ad);
    assign w_better = (r_p1 < r_p2) || ((r_p1 == r_p2) && (r_r > r_br));

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_as   <= sat_add(w_bits, w_ld_s);
            r_ad   <= sat_add(w_bits, w_ld_d);
            r_base <= umax(r_maxs[w_sel], r_maxd[w_sel]);
        end
        if (i_cmd.ev) begin
            r_q <= i_cmd.pass ? w_m : umax(r_base, w_m);
            r_r <= w_net_rate[w_sel];
        end
        if (i_cmd.mlo) begin
            r_m1lo <= MLW'(r_q[HB-1:0]) * MLW'(r_br);
            r_m2lo <= MLW'(r_bq[HB-1:0]) * MLW'(r_r);
        end
        if (i_cmd.mhi) begin
            r_m1hi <= MHW'(r_q[LB-1:HB]) * MHW'(r_br);
            r_m2hi <= MHW'(r_bq[LB-1:HB]) * MHW'(r_r);
        end
        if (i_cmd.add) begin
            r_p1 <= (PDW'(r_m1hi) << HB) + PDW'(r_m1lo);
            r_p2 <= (PDW'(r_m2hi) << HB) + PDW'(r_m2lo);
        end
        if (i_cmd.cmp && (!r_best_vld || w_better)) begin
            r_best <= w_sel;
            r_bq   <= r_q;
            r_br   <= r_r;
        end
        if (i_cmd.wld) begin
            r_ns <= sat_add(w_ld_s, w_bits);
            r_nd <= sat_add(w_ld_d, w_bits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
            r_crit     <= 1'b0;
        end else begin
            if (i_cmd.latch || i_cmd.pass_start) begin
                r_best_vld <= 1'b0;
            end else if (i_cmd.cmp) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_crit <= 1'b0;
            end else if (i_cmd.ev && !i_cmd.pass && (w_m > r_base)) begin
                r_crit <= 1'b1;
            end
        end
    end

    // Fastest enabled network for flows without demand.
    logic [NW-1:0]        w_fast_net;
    logic [RATE_BITS-1:0] w_fast_rate;
    logic                 w_fast_found;

    always_comb begin
        w_fast_net   = '0;
        w_fast_rate  = '0;
        w_fast_found = 1'b0;
        for (int n = 0; n < NETS; n++) begin
            if (w_net_rate[n] != '0 && (!w_fast_found || w_net_rate[n] > w_fast_rate)) begin
                w_fast_net   = NW'(n);
                w_fast_rate  = w_net_rate[n];
                w_fast_found = 1'b1;
            end
        end
    end

    t_result r_out;
    logic    r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit_dummy | i_cmd.emit_none | i_cmd.write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_dummy) begin
            r_out <= '{chosen_net: 2'(w_fast_net), raises_bottleneck: 1'b0,
                       load_saturated: 1'b0};
        end else if (i_cmd.emit_none) begin
            r_out <= '0;
        end else if (i_cmd.write) begin
            r_out <= '{chosen_net: 2'(r_best), raises_bottleneck: r_crit,
                       load_saturated: (&r_ns) || (&r_nd)};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    assign o_stat.need_sweep = i_req.first_of_group && (&r_epoch);
    assign o_stat.sweep_last = &r_sweep;
    assign o_stat.has_demand = r_req.has_demand;
    assign o_stat.rate_zero  = (w_net_rate[w_sel] == '0);
    assign o_stat.best_vld   = r_best_vld;
    assign o_stat.crit       = r_crit;
    assign o_stat.mode       = r_mode;

endmodule

// ----- design/ftnp_checker.sv -----
module ftnp_checker #(
    parameter int NETS = ftnp_pkg::NETS_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input ftnp_pkg::t_result o_result
);

    // Result strobes never come back to back.
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result strobes");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking a request");

    a_no_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result strobe right after a request was taken");

    a_net_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (int'(o_result.chosen_net) < NETS))
        else $error("chosen network out of range");

endmodule

bind flow_to_network_placement ftnp_checker #(
    .NETS (NETS)
) u_ftnp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
